FILE: design/ltscan_pkg.sv
// Package: types, codes and the per-character scan step of the lexical token scanner.
`timescale 1ns / 1ps
package ltscan_pkg;

    localparam int LINE_BITS  = 16;
    localparam int COL_BITS   = 16;
    localparam int OUT_W      = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = 2;
    localparam int CNT_BITS   = 3;
    localparam int TDATA_W    = 72;

    localparam logic [7:0] TAB_RESET = 8'd4;
    localparam logic [2:0] NM_FULL   = 3'd4;
    localparam logic [2:0] NM_FAIL   = 3'd7;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_ERROR  = 6'd1;
    localparam logic [5:0] K_IDENT  = 6'd2;
    localparam logic [5:0] K_NULL   = 6'd3;
    localparam logic [5:0] K_INT    = 6'd4;
    localparam logic [5:0] K_OCT    = 6'd5;
    localparam logic [5:0] K_DEC    = 6'd6;
    localparam logic [5:0] K_HEX    = 6'd7;
    localparam logic [5:0] K_FLOAT  = 6'd8;
    localparam logic [5:0] K_STRING = 6'd9;
    localparam logic [5:0] K_ASI    = 6'd10;
    localparam logic [5:0] K_EQ     = 6'd11;
    localparam logic [5:0] K_MATCH  = 6'd12;
    localparam logic [5:0] K_LT     = 6'd13;
    localparam logic [5:0] K_LE     = 6'd14;
    localparam logic [5:0] K_GT     = 6'd15;
    localparam logic [5:0] K_GE     = 6'd16;
    localparam logic [5:0] K_NE     = 6'd17;
    localparam logic [5:0] K_AND    = 6'd18;
    localparam logic [5:0] K_OR     = 6'd19;
    localparam logic [5:0] K_PLUS   = 6'd20;
    localparam logic [5:0] K_PLUSEQ = 6'd21;
    localparam logic [5:0] K_MINUS  = 6'd22;
    localparam logic [5:0] K_MINEQ  = 6'd23;
    localparam logic [5:0] K_DOT    = 6'd24;
    localparam logic [5:0] K_DOLLAR = 6'd25;
    localparam logic [5:0] K_LPAR   = 6'd26;
    localparam logic [5:0] K_RPAR   = 6'd27;
    localparam logic [5:0] K_STAR   = 6'd28;
    localparam logic [5:0] K_COMMA  = 6'd29;
    localparam logic [5:0] K_COLON  = 6'd30;
    localparam logic [5:0] K_SEMI   = 6'd31;
    localparam logic [5:0] K_LBRK   = 6'd32;
    localparam logic [5:0] K_RBRK   = 6'd33;
    localparam logic [5:0] K_LBRC   = 6'd34;
    localparam logic [5:0] K_RBRC   = 6'd35;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_UNKNOWN = 2'd1;
    localparam logic [1:0] E_NEWLINE = 2'd2;
    localparam logic [1:0] E_UNTERM  = 2'd3;

    typedef enum logic [26:0] {
        S_START = 27'd1 << 0,  S_IDENT = 27'd1 << 1,  S_ZERO  = 27'd1 << 2,
        S_NZERO = 27'd1 << 3,  S_DEC   = 27'd1 << 4,  S_OCT   = 27'd1 << 5,
        S_HEX   = 27'd1 << 6,  S_HEX1  = 27'd1 << 7,  S_FLT0  = 27'd1 << 8,
        S_FLT1  = 27'd1 << 9,  S_FLT15 = 27'd1 << 10, S_FLT2  = 27'd1 << 11,
        S_FLT21 = 27'd1 << 12, S_FLT22 = 27'd1 << 13, S_SQUOT = 27'd1 << 14,
        S_DQUOT = 27'd1 << 15, S_DQESC = 27'd1 << 16, S_ASI   = 27'd1 << 17,
        S_LT    = 27'd1 << 18, S_GT    = 27'd1 << 19, S_NE    = 27'd1 << 20,
        S_AND   = 27'd1 << 21, S_OR    = 27'd1 << 22, S_PLUS  = 27'd1 << 23,
        S_MINUS = 27'd1 << 24, S_ENTER = 27'd1 << 25, S_DOT   = 27'd1 << 26
    } scan_state_t;

    typedef struct packed {
        scan_state_t          scan;
        logic [LINE_BITS-1:0] line;
        logic [COL_BITS-1:0]  col;
        logic [LINE_BITS-1:0] sline;
        logic [COL_BITS-1:0]  scol;
        logic [2:0]           nm;
    } scan_t;

    typedef struct packed {
        logic             tv;
        logic [7:0]       tc;
        logic             te;
        logic [5:0]       kind;
        logic [1:0]       err;
        logic [OUT_W-1:0] line;
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] ecol;
    } res_t;

    typedef struct packed {
        scan_t st;
        res_t  res;
        logic  redo;
    } step_t;

    typedef struct packed {
        res_t res;
        logic last;
    } entry_t;

    function automatic logic [COL_BITS-1:0] col_sat(logic [COL_BITS-1:0] col, logic [7:0] n);
        logic [COL_BITS:0] s;
        s = {1'b0, col} + {{(COL_BITS + 1 - 8){1'b0}}, n};
        return s[COL_BITS] ? {COL_BITS{1'b1}} : s[COL_BITS-1:0];
    endfunction

    function automatic logic [LINE_BITS-1:0] line_inc(logic [LINE_BITS-1:0] line);
        return (&line) ? line : line + {{(LINE_BITS - 1){1'b0}}, 1'b1};
    endfunction

    function automatic logic [2:0] nm_next(logic [2:0] nm, logic [7:0] c);
        logic [7:0] want;
        case (nm)
            3'd0: want = "n";
            3'd1: want = "u";
            default: want = "l";
        endcase
        return (nm < NM_FULL && c == want) ? nm + 3'd1 : NM_FAIL;
    endfunction

    function automatic logic [7:0] escape_byte(logic [7:0] c);
        case (c)
            "a": return 8'd7;
            "b": return 8'd8;
            "f": return 8'd12;
            "n": return 8'd10;
            "r": return 8'd13;
            "t": return 8'd9;
            default: return c;
        endcase
    endfunction

    function automatic logic [5:0] punct_kind(logic [7:0] c);
        case (c)
            "$": return K_DOLLAR;
            "(": return K_LPAR;
            ")": return K_RPAR;
            "*": return K_STAR;
            ",": return K_COMMA;
            ":": return K_COLON;
            ";": return K_SEMI;
            "[": return K_LBRK;
            "]": return K_RBRK;
            "{": return K_LBRC;
            "}": return K_RBRC;
            default: return K_EOF;
        endcase
    endfunction

    function automatic step_t fin(step_t r, logic [5:0] kind);
        r.res.te   = 1'b1;
        r.res.kind = kind;
        r.res.line = OUT_W'(r.st.sline);
        r.res.col  = OUT_W'(r.st.scol);
        r.st.scan  = S_START;
        return r;
    endfunction

    function automatic step_t flt(step_t r, logic [1:0] err);
        r.res.err  = err;
        r.res.ecol = OUT_W'(r.st.col);
        return fin(r, K_ERROR);
    endfunction

    // One examination of a character (or of end of input) in the current state.
    function automatic step_t examine(scan_t s, logic [7:0] c, logic eof, logic [7:0] tab);
        step_t      r;
        logic       save;
        logic [7:0] oc;
        logic       dg, al, hx, ep, od, sg;
        logic [5:0] base, pk;
        logic [7:0] want;
        r      = '0;
        r.st   = s;
        save   = 1'b1;
        oc     = c;
        dg     = !eof && c >= "0" && c <= "9";
        od     = !eof && c >= "0" && c <= "7";
        al     = !eof && (c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
        hx     = dg || (!eof && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")));
        ep     = !eof && (c == "e" || c == "E");
        sg     = !eof && (c == "+" || c == "-");
        pk     = eof ? K_EOF : punct_kind(c);
        base   = K_LT;
        want   = "=";
        case (s.scan)
            S_IDENT: begin
                if (al || dg) begin
                    r.st.nm  = nm_next(s.nm, c);
                    r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1;
                    r = fin(r, (s.nm == NM_FULL) ? K_NULL : K_IDENT);
                end
            end
            S_ZERO: begin
                if (!eof && (c == "x" || c == "X")) begin
                    r.st.scan = S_HEX; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == ".") begin
                    r.st.scan = S_FLT1; r.st.col = col_sat(s.col, 8'd1);
                end else if (ep) begin
                    r.st.scan = S_FLT2; r.st.col = col_sat(s.col, 8'd1);
                end else if (od) begin
                    r.st.scan = S_OCT; r.st.col = col_sat(s.col, 8'd1);
                end else if (dg) begin
                    r.st.scan = S_FLT0; r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = fin(r, K_INT);
                end
            end
            S_NZERO, S_DEC: begin
                if (dg) begin
                    r.st.scan = S_DEC; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == ".") begin
                    r.st.scan = S_FLT1; r.st.col = col_sat(s.col, 8'd1);
                end else if (ep) begin
                    r.st.scan = S_FLT2; r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1;
                    r = fin(r, (s.scan == S_DEC) ? K_DEC : K_INT);
                end
            end
            S_OCT: begin
                if (od) begin
                    r.st.col = col_sat(s.col, 8'd1);
                end else if (dg) begin
                    r.st.scan = S_FLT0; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == ".") begin
                    r.st.scan = S_FLT1; r.st.col = col_sat(s.col, 8'd1);
                end else if (ep) begin
                    r.st.scan = S_FLT2; r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = fin(r, K_OCT);
                end
            end
            S_HEX: begin
                if (hx) begin
                    r.st.scan = S_HEX1; r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = flt(r, E_UNKNOWN);
                end
            end
            S_HEX1: begin
                if (hx) begin
                    r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = fin(r, K_HEX);
                end
            end
            S_FLT0: begin
                if (!eof && c == ".") begin
                    r.st.scan = S_FLT1; r.st.col = col_sat(s.col, 8'd1);
                end else if (ep) begin
                    r.st.scan = S_FLT2; r.st.col = col_sat(s.col, 8'd1);
                end else if (dg) begin
                    r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = fin(r, K_INT);
                end
            end
            S_FLT1: begin
                if (dg) begin
                    r.st.scan = S_FLT15; r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = fin(r, K_FLOAT);
                end
            end
            S_FLT15: begin
                if (ep) begin
                    r.st.scan = S_FLT2; r.st.col = col_sat(s.col, 8'd1);
                end else if (dg) begin
                    r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = fin(r, K_FLOAT);
                end
            end
            S_FLT2: begin
                r.st.scan = S_FLT21;
                if (sg) begin
                    r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1;
                end
            end
            S_FLT21: begin
                if (dg) begin
                    r.st.scan = S_FLT22; r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = flt(r, E_UNKNOWN);
                end
            end
            S_FLT22: begin
                if (dg) begin
                    r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = fin(r, K_FLOAT);
                end
            end
            S_SQUOT, S_DQUOT: begin
                if (s.scan == S_DQUOT && !eof && c == "\\") begin
                    save = 1'b0; r.st.scan = S_DQESC; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && ((s.scan == S_SQUOT && c == "'")
                                      || (s.scan == S_DQUOT && c == "\""))) begin
                    save = 1'b0; r = fin(r, K_STRING); r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && (c == "\n" || c == "\r")) begin
                    save = 1'b0; r = flt(r, E_NEWLINE);
                    r.st.line = line_inc(s.line);
                    r.st.col  = {{(COL_BITS - 1){1'b0}}, 1'b1};
                end else if (eof) begin
                    save = 1'b0; r.redo = 1'b1; r = flt(r, E_UNTERM);
                end else begin
                    r.st.col = col_sat(s.col, 8'd1);
                end
            end
            S_DQESC: begin
                if (eof) begin
                    save = 1'b0; r.redo = 1'b1; r = flt(r, E_UNTERM);
                end else begin
                    r.st.scan = S_DQUOT; oc = escape_byte(c);
                end
            end
            S_ASI: begin
                if (!eof && c == "=") begin
                    r = fin(r, K_EQ); r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == "~") begin
                    r = fin(r, K_MATCH); r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = fin(r, K_ASI);
                end
            end
            S_LT, S_GT, S_PLUS, S_MINUS: begin
                base = (s.scan == S_LT) ? K_LT : (s.scan == S_GT) ? K_GT :
                       (s.scan == S_PLUS) ? K_PLUS : K_MINUS;
                if (!eof && c == "=") begin
                    r = fin(r, base + 6'd1); r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = fin(r, base);
                end
            end
            S_NE, S_AND, S_OR: begin
                want = (s.scan == S_NE) ? "=" : (s.scan == S_AND) ? "&" : "|";
                base = (s.scan == S_NE) ? K_NE : (s.scan == S_AND) ? K_AND : K_OR;
                if (!eof && c == want) begin
                    r = fin(r, base); r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = flt(r, E_UNKNOWN);
                end
            end
            S_DOT: begin
                if (dg) begin
                    r.st.scan = S_FLT1; r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    save = 1'b0; r.redo = 1'b1; r = fin(r, K_DOT);
                end
            end
            S_ENTER: begin
                r.redo    = eof || c != "\n";
                save      = 1'b0;
                r.st.scan = S_START;
                r.st.line = line_inc(s.line);
                r.st.col  = {{(COL_BITS - 1){1'b0}}, 1'b1};
            end
            default: begin
                r.st.scan  = S_START;
                r.st.sline = s.line;
                r.st.scol  = s.col;
                if (al) begin
                    r.st.nm = nm_next(3'd0, c); r.st.scan = S_IDENT;
                    r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == "0") begin
                    r.st.scan = S_ZERO; r.st.col = col_sat(s.col, 8'd1);
                end else if (dg) begin
                    r.st.scan = S_NZERO; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == " ") begin
                    save = 1'b0; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == "\t") begin
                    save = 1'b0; r.st.col = col_sat(s.col, tab);
                end else if (!eof && c == "\n") begin
                    save = 1'b0; r.st.line = line_inc(s.line);
                    r.st.col = {{(COL_BITS - 1){1'b0}}, 1'b1};
                end else if (!eof && c == "\r") begin
                    save = 1'b0; r.st.scan = S_ENTER;
                end else if (!eof && c == "'") begin
                    save = 1'b0; r.st.scan = S_SQUOT; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == "\"") begin
                    save = 1'b0; r.st.scan = S_DQUOT; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == "=") begin
                    r.st.scan = S_ASI; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == "<") begin
                    r.st.scan = S_LT; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == ">") begin
                    r.st.scan = S_GT; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == "!") begin
                    r.st.scan = S_NE; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == "&") begin
                    r.st.scan = S_AND; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == "|") begin
                    r.st.scan = S_OR; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == "+") begin
                    r.st.scan = S_PLUS; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == "-") begin
                    r.st.scan = S_MINUS; r.st.col = col_sat(s.col, 8'd1);
                end else if (!eof && c == ".") begin
                    r.st.scan = S_DOT; r.st.col = col_sat(s.col, 8'd1);
                end else if (eof) begin
                    save = 1'b0; r = fin(r, K_EOF);
                end else if (pk != K_EOF) begin
                    r = fin(r, pk); r.st.col = col_sat(s.col, 8'd1);
                end else begin
                    r = flt(r, E_UNKNOWN); r.st.col = col_sat(s.col, 8'd1);
                end
            end
        endcase
        if (save && !eof) begin
            r.res.tv = 1'b1;
            r.res.tc = oc;
        end
        return r;
    endfunction

endpackage

FILE: design/lexical_token_scanner.sv
// Top level: character-stream lexical token scanner with result queue.
// Results are written to the result queue on their character transfer and offered on m_ in order.
// Throughput: one character per cycle; a character giving two results takes
//   two queue entries, only the second with m_tlast set; input stalls while
//   more than two of the 4 result queue entries are in use.
// Reset (aresetn low, synchronous): start state, line/column 1, tab width 4,
//   result queue empty.
`timescale 1ns / 1ps
module lexical_token_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] text_valid, [8:1] text_char, [9] token_end, [15:10] token_kind,
    // [17:16] error_kind, [33:18] token_line, [49:34] token_col,
    // [65:50] error_col, [71:66] zero
    output logic [ltscan_pkg::TDATA_W-1:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [7:0]                       tab_reg;
    ltscan_pkg::scan_t                st_reg, st_next;
    ltscan_pkg::entry_t               fifo_reg [ltscan_pkg::FIFO_DEPTH];
    logic [ltscan_pkg::PTR_BITS-1:0]  head_reg, tail_reg;
    logic [ltscan_pkg::CNT_BITS-1:0]  count_reg, count_next;
    ltscan_pkg::step_t                e1, e2, e3;
    logic                             v1, v2, v3, s_xfer, m_xfer;
    logic [1:0]                       npush;
    ltscan_pkg::entry_t               slot0, slot1;
    ltscan_pkg::entry_t               head_e;

    assign cfg_ready = 1'b1;
    assign s_tready  = count_reg <= ltscan_pkg::CNT_BITS'(ltscan_pkg::FIFO_DEPTH - 2);
    assign s_xfer    = s_tvalid && s_tready;
    assign m_tvalid  = count_reg != '0;
    assign m_xfer    = m_tvalid && m_tready;

    always_comb begin
        e1 = ltscan_pkg::examine(st_reg, s_tdata, s_tuser, tab_reg);
        e2 = ltscan_pkg::examine(e1.st, s_tdata, s_tuser, tab_reg);
        e3 = ltscan_pkg::examine(e2.st, s_tdata, s_tuser, tab_reg);
        v1 = e1.res.tv || e1.res.te;
        v2 = e1.redo && (e2.res.tv || e2.res.te);
        v3 = e1.redo && e2.redo && (e3.res.tv || e3.res.te);
        st_next = !e1.redo ? e1.st : (!e2.redo ? e2.st : e3.st);
        npush = 2'(v1) + 2'(v2) + 2'(v3);
        slot0.res  = v1 ? e1.res : (v2 ? e2.res : e3.res);
        slot0.last = npush == 2'd1;
        slot1.res  = (v1 && v2) ? e2.res : e3.res;
        slot1.last = 1'b1;
        if (!s_xfer) begin
            npush = 2'd0;
        end
        count_next = count_reg + ltscan_pkg::CNT_BITS'(npush)
                     - ltscan_pkg::CNT_BITS'(m_xfer);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_reg      <= ltscan_pkg::TAB_RESET;
            st_reg.scan  <= ltscan_pkg::S_START;
            st_reg.line  <= ltscan_pkg::LINE_BITS'(1);
            st_reg.col   <= ltscan_pkg::COL_BITS'(1);
            st_reg.sline <= ltscan_pkg::LINE_BITS'(1);
            st_reg.scol  <= ltscan_pkg::COL_BITS'(1);
            st_reg.nm    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                tab_reg <= cfg_data;
            end
            if (s_xfer) begin
                st_reg <= st_next;
            end
            if (m_xfer) begin
                head_reg <= head_reg + 1'b1;
            end
            tail_reg  <= tail_reg + ltscan_pkg::PTR_BITS'(npush);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (npush != 2'd0) begin
            fifo_reg[tail_reg] <= slot0;
        end
        if (npush == 2'd2) begin
            fifo_reg[tail_reg + 1'b1] <= slot1;
        end
    end

    assign head_e  = fifo_reg[head_reg];
    assign m_tlast = head_e.last;
    assign m_tdata = {6'd0, head_e.res.ecol, head_e.res.col, head_e.res.line,
                      head_e.res.err, head_e.res.kind, head_e.res.te,
                      head_e.res.tc, head_e.res.tv};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ltscan_pkg::CNT_BITS'(ltscan_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_kind_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[9]) |-> (m_tdata[15:10] == ltscan_pkg::K_EOF))
        else $error("token kind without token end");

    a_err_is_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[17:16] != ltscan_pkg::E_NONE)
            |-> (m_tdata[15:10] == ltscan_pkg::K_ERROR))
        else $error("error code on non-error token");

endmodule

FILE: tb/tb_top.sv
// Testbench for lexical_token_scanner: directed and random character streams checked by a scanner model.
`timescale 1ns / 1ps
module tb_top;

    localparam int LIMIT = 1000000;
    localparam logic [7:0] CR = 8'd13;
    localparam logic [7:0] LF = 8'd10;
    localparam logic [7:0] TAB = 8'd9;

    typedef enum {
        SC_START, SC_IDENT, SC_ZERO, SC_NZERO, SC_DEC, SC_OCT, SC_HEX, SC_HEX1,
        SC_FLT0, SC_FLT1, SC_FLT15, SC_FLT2, SC_FLT21, SC_FLT22, SC_SQUOT, SC_DQUOT,
        SC_DQESC, SC_ASI, SC_LT, SC_GT, SC_NE, SC_AND, SC_OR, SC_PLUS, SC_MINUS,
        SC_ENTER, SC_DOT
    } lex_state_t;

    typedef struct packed {
        bit        tv;
        bit [7:0]  tc;
        bit        te;
        bit [5:0]  kind;
        bit [1:0]  err;
        bit [15:0] line;
        bit [15:0] col;
        bit [15:0] ecol;
        bit        last;
    } tok_res_t;

    typedef struct {
        bit [7:0] ch;
        bit       eof;
        tok_res_t want;
    } fixed_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [ltscan_pkg::TDATA_W-1:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 0;

    lexical_token_scanner i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // scanner model state
    lex_state_t lx_st = SC_START;
    int         lx_line = 1, lx_col = 1, lx_sline = 1, lx_scol = 1, lx_nm = 0;
    bit [7:0]   lx_tab = 8'd4;

    tok_res_t   token_q[$];
    tok_res_t   fixed_q[$];
    int         fails = 0, n_chars = 0, n_results = 0, n_ends = 0, cycles = 0;
    int         burst = 0;
    bit         hold = 0, rnd_phase = 0;

    function automatic void col_add(int n);
        lx_col += n;
        if (lx_col > 65535) lx_col = 65535;
    endfunction

    function automatic void line_next();
        if (lx_line < 65535) lx_line++;
        lx_col = 1;
    endfunction

    function automatic void close_tok(ref tok_res_t r, input bit [5:0] kind);
        r.te = 1;
        r.kind = kind;
        r.line = lx_sline[15:0];
        r.col = lx_scol[15:0];
        lx_st = SC_START;
    endfunction

    function automatic void bad_tok(ref tok_res_t r, input bit [1:0] err);
        r.err = err;
        r.ecol = lx_col[15:0];
        close_tok(r, ltscan_pkg::K_ERROR);
    endfunction

    function automatic int null_next(int nm, bit [7:0] c);
        if (nm == 0 && c == "n") return 1;
        if (nm == 1 && c == "u") return 2;
        if ((nm == 2 || nm == 3) && c == "l") return nm + 1;
        return 7;
    endfunction

    // one pass over a character; returns 1 when the character must be scanned again
    function automatic bit scan_once(bit [7:0] c, bit e, ref tok_res_t r);
        bit save, redo, dg, od, al, hx, ep, sg;
        bit [7:0] oc;
        bit [5:0] base;
        bit [7:0] want;
        save = 1; redo = 0; oc = c;
        dg = !e && c >= "0" && c <= "9";
        od = !e && c >= "0" && c <= "7";
        al = !e && (c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
        hx = dg || (!e && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")));
        ep = !e && (c == "e" || c == "E");
        sg = !e && (c == "+" || c == "-");
        case (lx_st)
            SC_IDENT: begin
                if (al || dg) begin
                    lx_nm = null_next(lx_nm, c); col_add(1);
                end else begin
                    save = 0; redo = 1;
                    close_tok(r, lx_nm == 4 ? ltscan_pkg::K_NULL : ltscan_pkg::K_IDENT);
                end
            end
            SC_ZERO: begin
                if (!e && (c == "x" || c == "X")) begin lx_st = SC_HEX; col_add(1); end
                else if (!e && c == ".") begin lx_st = SC_FLT1; col_add(1); end
                else if (ep) begin lx_st = SC_FLT2; col_add(1); end
                else if (od) begin lx_st = SC_OCT; col_add(1); end
                else if (dg) begin lx_st = SC_FLT0; col_add(1); end
                else begin save = 0; redo = 1; close_tok(r, ltscan_pkg::K_INT); end
            end
            SC_NZERO, SC_DEC: begin
                if (dg) begin lx_st = SC_DEC; col_add(1); end
                else if (!e && c == ".") begin lx_st = SC_FLT1; col_add(1); end
                else if (ep) begin lx_st = SC_FLT2; col_add(1); end
                else begin
                    save = 0; redo = 1;
                    close_tok(r, lx_st == SC_DEC ? ltscan_pkg::K_DEC : ltscan_pkg::K_INT);
                end
            end
            SC_OCT: begin
                if (od) col_add(1);
                else if (dg) begin lx_st = SC_FLT0; col_add(1); end
                else if (!e && c == ".") begin lx_st = SC_FLT1; col_add(1); end
                else if (ep) begin lx_st = SC_FLT2; col_add(1); end
                else begin save = 0; redo = 1; close_tok(r, ltscan_pkg::K_OCT); end
            end
            SC_HEX: begin
                if (hx) begin lx_st = SC_HEX1; col_add(1); end
                else begin save = 0; redo = 1; bad_tok(r, ltscan_pkg::E_UNKNOWN); end
            end
            SC_HEX1: begin
                if (hx) col_add(1);
                else begin save = 0; redo = 1; close_tok(r, ltscan_pkg::K_HEX); end
            end
            SC_FLT0: begin
                if (!e && c == ".") begin lx_st = SC_FLT1; col_add(1); end
                else if (ep) begin lx_st = SC_FLT2; col_add(1); end
                else if (dg) col_add(1);
                else begin save = 0; redo = 1; close_tok(r, ltscan_pkg::K_INT); end
            end
            SC_FLT1: begin
                if (dg) begin lx_st = SC_FLT15; col_add(1); end
                else begin save = 0; redo = 1; close_tok(r, ltscan_pkg::K_FLOAT); end
            end
            SC_FLT15: begin
                if (ep) begin lx_st = SC_FLT2; col_add(1); end
                else if (dg) col_add(1);
                else begin save = 0; redo = 1; close_tok(r, ltscan_pkg::K_FLOAT); end
            end
            SC_FLT2: begin
                lx_st = SC_FLT21;
                if (sg) col_add(1);
                else begin save = 0; redo = 1; end
            end
            SC_FLT21: begin
                if (dg) begin lx_st = SC_FLT22; col_add(1); end
                else begin save = 0; redo = 1; bad_tok(r, ltscan_pkg::E_UNKNOWN); end
            end
            SC_FLT22: begin
                if (dg) col_add(1);
                else begin save = 0; redo = 1; close_tok(r, ltscan_pkg::K_FLOAT); end
            end
            SC_SQUOT, SC_DQUOT: begin
                if (lx_st == SC_DQUOT && !e && c == "\\") begin
                    save = 0; lx_st = SC_DQESC; col_add(1);
                end else if (!e && ((lx_st == SC_SQUOT && c == "'")
                                    || (lx_st == SC_DQUOT && c == "\""))) begin
                    save = 0; close_tok(r, ltscan_pkg::K_STRING); col_add(1);
                end else if (!e && (c == LF || c == CR)) begin
                    save = 0; bad_tok(r, ltscan_pkg::E_NEWLINE); line_next();
                end else if (e) begin
                    save = 0; redo = 1; bad_tok(r, ltscan_pkg::E_UNTERM);
                end else col_add(1);
            end
            SC_DQESC: begin
                if (e) begin save = 0; redo = 1; bad_tok(r, ltscan_pkg::E_UNTERM); end
                else begin
                    lx_st = SC_DQUOT;
                    case (c)
                        "a": oc = 8'd7;
                        "b": oc = 8'd8;
                        "f": oc = 8'd12;
                        "n": oc = 8'd10;
                        "r": oc = 8'd13;
                        "t": oc = 8'd9;
                        default: oc = c;
                    endcase
                end
            end
            SC_ASI: begin
                if (!e && c == "=") begin close_tok(r, ltscan_pkg::K_EQ); col_add(1); end
                else if (!e && c == "~") begin
                    close_tok(r, ltscan_pkg::K_MATCH); col_add(1);
                end
                else begin save = 0; redo = 1; close_tok(r, ltscan_pkg::K_ASI); end
            end
            SC_LT, SC_GT, SC_PLUS, SC_MINUS: begin
                base = lx_st == SC_LT ? ltscan_pkg::K_LT : lx_st == SC_GT ? ltscan_pkg::K_GT :
                       lx_st == SC_PLUS ? ltscan_pkg::K_PLUS : ltscan_pkg::K_MINUS;
                if (!e && c == "=") begin close_tok(r, base + 6'd1); col_add(1); end
                else begin save = 0; redo = 1; close_tok(r, base); end
            end
            SC_NE, SC_AND, SC_OR: begin
                want = lx_st == SC_NE ? "=" : lx_st == SC_AND ? "&" : "|";
                base = lx_st == SC_NE ? ltscan_pkg::K_NE : lx_st == SC_AND ? ltscan_pkg::K_AND :
                       ltscan_pkg::K_OR;
                if (!e && c == want) begin close_tok(r, base); col_add(1); end
                else begin save = 0; redo = 1; bad_tok(r, ltscan_pkg::E_UNKNOWN); end
            end
            SC_DOT: begin
                if (dg) begin lx_st = SC_FLT1; col_add(1); end
                else begin save = 0; redo = 1; close_tok(r, ltscan_pkg::K_DOT); end
            end
            SC_ENTER: begin
                redo = e || c != LF;
                save = 0;
                lx_st = SC_START;
                line_next();
            end
            default: begin
                lx_st = SC_START;
                lx_sline = lx_line;
                lx_scol = lx_col;
                if (e) begin save = 0; close_tok(r, ltscan_pkg::K_EOF); end
                else if (al) begin lx_nm = null_next(0, c); lx_st = SC_IDENT; col_add(1); end
                else if (c == "0") begin lx_st = SC_ZERO; col_add(1); end
                else if (dg) begin lx_st = SC_NZERO; col_add(1); end
                else if (c == " ") begin save = 0; col_add(1); end
                else if (c == TAB) begin save = 0; col_add(lx_tab); end
                else if (c == LF) begin save = 0; line_next(); end
                else if (c == CR) begin save = 0; lx_st = SC_ENTER; end
                else if (c == "'") begin save = 0; lx_st = SC_SQUOT; col_add(1); end
                else if (c == "\"") begin save = 0; lx_st = SC_DQUOT; col_add(1); end
                else if (c == "=") begin lx_st = SC_ASI; col_add(1); end
                else if (c == "<") begin lx_st = SC_LT; col_add(1); end
                else if (c == ">") begin lx_st = SC_GT; col_add(1); end
                else if (c == "!") begin lx_st = SC_NE; col_add(1); end
                else if (c == "&") begin lx_st = SC_AND; col_add(1); end
                else if (c == "|") begin lx_st = SC_OR; col_add(1); end
                else if (c == "+") begin lx_st = SC_PLUS; col_add(1); end
                else if (c == "-") begin lx_st = SC_MINUS; col_add(1); end
                else if (c == ".") begin lx_st = SC_DOT; col_add(1); end
                else begin
                    case (c)
                        "$": base = ltscan_pkg::K_DOLLAR;
                        "(": base = ltscan_pkg::K_LPAR;
                        ")": base = ltscan_pkg::K_RPAR;
                        "*": base = ltscan_pkg::K_STAR;
                        ",": base = ltscan_pkg::K_COMMA;
                        ":": base = ltscan_pkg::K_COLON;
                        ";": base = ltscan_pkg::K_SEMI;
                        "[": base = ltscan_pkg::K_LBRK;
                        "]": base = ltscan_pkg::K_RBRK;
                        "{": base = ltscan_pkg::K_LBRC;
                        "}": base = ltscan_pkg::K_RBRC;
                        default: base = ltscan_pkg::K_ERROR;
                    endcase
                    if (base == ltscan_pkg::K_ERROR) bad_tok(r, ltscan_pkg::E_UNKNOWN);
                    else close_tok(r, base);
                    col_add(1);
                end
            end
        endcase
        if (save && !e) begin
            r.tv = 1;
            r.tc = oc;
        end
        return redo;
    endfunction

    function automatic void predict_char(bit [7:0] c, bit e);
        tok_res_t r;
        tok_res_t got[2];
        int n;
        bit again;
        n = 0;
        again = 1;
        for (int p = 0; p < 4 && again && n < 2; p++) begin
            r = '0;
            again = scan_once(c, e, r);
            if (r.tv || r.te) begin
                got[n] = r;
                n++;
            end
        end
        if (n > 0) got[n-1].last = 1;
        for (int i = 0; i < n; i++) begin
            if (fixed_q.size() != 0) token_q.push_back(fixed_q.pop_front());
            else token_q.push_back(got[i]);
        end
    endfunction

    function automatic tok_res_t unpack_res(logic [ltscan_pkg::TDATA_W-1:0] d, logic l);
        tok_res_t r;
        r.tv = d[0]; r.tc = d[8:1]; r.te = d[9]; r.kind = d[15:10]; r.err = d[17:16];
        r.line = d[33:18]; r.col = d[49:34]; r.ecol = d[65:50]; r.last = l;
        return r;
    endfunction

    always @(posedge aclk) begin
        tok_res_t act, exp_r;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready) begin
            predict_char(s_tdata, s_tuser);
            n_chars++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            act = unpack_res(m_tdata, m_tlast);
            n_results++;
            if (act.te) n_ends++;
            if (token_q.size() == 0) begin
                fails++;
                $display("%0t: unexpected result %p", $time, act);
            end else begin
                exp_r = token_q.pop_front();
                if (act != exp_r || m_tdata[71:66] != 0) begin
                    fails++;
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, act);
                end
            end
        end
    end

    // receiver: stall pattern rotates through four modes, plus one long hold
    always @(posedge aclk) begin
        int mode;
        mode = (cycles / 64) % 4;
        if (hold) m_tready <= 0;
        else if (mode == 0) m_tready <= 1;
        else if (mode == 1) m_tready <= $urandom_range(0, 1);
        else if (mode == 2) m_tready <= ($urandom_range(0, 3) == 0);
        else m_tready <= ($urandom_range(0, 7) != 0);
    end

    initial begin
        wait (rnd_phase);
        repeat (150) @(posedge aclk);
        hold = 1;
        repeat (300) @(posedge aclk);
        hold = 0;
    end

    task automatic put(bit [7:0] c, bit e);
        if (burst == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst = $urandom_range(1, 30);
        end
        s_tvalid <= 1;
        s_tdata <= c;
        s_tuser <= e;
        burst--;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic put_str(string t);
        for (int i = 0; i < t.len(); i++) put(t[i], 0);
    endtask

    task automatic settle();
        burst = 0;
        s_tvalid <= 0;
        @(posedge aclk);
        while (token_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_tab(bit [7:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        lx_tab = v;
    endtask

    function automatic bit [7:0] rnd_alpha();
        int k;
        k = $urandom_range(0, 52);
        if (k == 52) return "_";
        return k < 26 ? "a" + k : "A" + k - 26;
    endfunction

    function automatic bit [7:0] rnd_digit(int hi);
        return "0" + $urandom_range(0, hi);
    endfunction

    task automatic rnd_token();
        int k, n;
        string ops[$];
        ops = '{"=", "==", "=~", "<", "<=", ">", ">=", "!=", "&&", "||", "+", "+=",
                "-", "-=", ".", "$", "(", ")", "*", ",", ":", ";", "[", "]", "{", "}"};
        k = $urandom_range(0, 99);
        if (k < 18) begin
            if ($urandom_range(0, 4) == 0) put_str($urandom_range(0, 1) ? "null" : "nul");
            else put(rnd_alpha(), 0);
            n = $urandom_range(0, 6);
            repeat (n) put($urandom_range(0, 2) ? rnd_alpha() : rnd_digit(9), 0);
        end else if (k < 36) begin
            case ($urandom_range(0, 4))
                0: put(rnd_digit(9), 0);
                1: begin put("0", 0); repeat ($urandom_range(1, 4)) put(rnd_digit(7), 0); end
                2: begin put(rnd_digit(9), 0); repeat ($urandom_range(1, 4)) put(rnd_digit(9), 0); end
                3: begin
                    put("0", 0); put($urandom_range(0, 1) ? "x" : "X", 0);
                    repeat ($urandom_range(0, 4))
                        put($urandom_range(0, 1) ? rnd_digit(9) : "a" + $urandom_range(0, 6), 0);
                end
                default: begin
                    put("0", 0); repeat ($urandom_range(0, 3)) put(rnd_digit(9), 0);
                end
            endcase
        end else if (k < 48) begin
            if ($urandom_range(0, 3) == 0) put(".", 0);
            else repeat ($urandom_range(1, 3)) put(rnd_digit(9), 0);
            if ($urandom_range(0, 1)) begin
                put(".", 0); repeat ($urandom_range(0, 3)) put(rnd_digit(9), 0);
            end
            if ($urandom_range(0, 1)) begin
                put($urandom_range(0, 1) ? "e" : "E", 0);
                n = $urandom_range(0, 3);
                if (n == 1) put("+", 0);
                if (n == 2) put("-", 0);
                repeat ($urandom_range(0, 3)) put(rnd_digit(9), 0);
            end
        end else if (k < 62) begin
            n = $urandom_range(0, 1);
            put(n ? "\"" : "'", 0);
            repeat ($urandom_range(0, 6)) begin
                if (n && $urandom_range(0, 3) == 0) begin
                    put("\\", 0); put($urandom_range(0, 255), 0);
                end else if ($urandom_range(0, 29) == 0) put($urandom_range(0, 1) ? CR : LF, 0);
                else put($urandom_range(32, 255), 0);
            end
            if ($urandom_range(0, 9) != 0) put(n ? "\"" : "'", 0);
        end else if (k < 82) begin
            put_str(ops[$urandom_range(0, ops.size() - 1)]);
        end else if (k < 90) begin
            put($urandom_range(0, 255), 0);
        end else if (k < 93) begin
            put($urandom_range(0, 255), 1);
        end else begin
            put($urandom_range(0, 3) == 0 ? TAB : " ", 0);
        end
        n = $urandom_range(0, 5);
        if (n == 0) put(" ", 0);
        else if (n == 1) put(LF, 0);
        else if (n == 2) begin put(CR, 0); if ($urandom_range(0, 1)) put(LF, 0); end
    endtask

    initial begin
        fixed_row_t fixed_rows[3];
        string frags[$];
        int start_chars;
        fixed_rows[0] = '{"$", 0, '{1, "$", 1, ltscan_pkg::K_DOLLAR, ltscan_pkg::E_NONE,
                                     1, 1, 0, 1}};
        fixed_rows[1] = '{"@", 0, '{1, "@", 1, ltscan_pkg::K_ERROR, ltscan_pkg::E_UNKNOWN,
                                     1, 2, 2, 1}};
        fixed_rows[2] = '{8'hFF, 1, '{0, 0, 1, ltscan_pkg::K_EOF, ltscan_pkg::E_NONE,
                                       1, 3, 0, 1}};
        frags = '{"null nul nulls x_9 ", "0 07 08 019 12 ", "0x1F 0xg 0X ",
                  "1.5e+3 .5 1e5 1e- 3.E9 ", "'a\nb' '\\' ", "\"e\\n\\a\\b\\f\\r\\t\\q\" ",
                  "== =~ = <= < >= > != !x && &x || |x += + -= - . ",
                  "$(){}[]*,:; \t\n"};

        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed part
        foreach (fixed_rows[i]) begin
            fixed_q.push_back(fixed_rows[i].want);
            put(fixed_rows[i].ch, fixed_rows[i].eof);
        end
        foreach (frags[i]) put_str(frags[i]);
        put(CR, 0); put(LF, 0); put(CR, 0); put("a", 0);
        put_str("\"ab"); put(CR, 0); put(LF, 0);
        put_str("\"x\\"); put(0, 1); put(0, 1);
        put_str("'open"); put(0, 1);
        settle();

        // wide tab saturates the column counter
        set_tab(8'd255);
        burst = 400;
        repeat (300) put(TAB, 0);
        put_str("ab "); put(TAB, 0); put("+", 0); put(0, 1); put(LF, 0);
        settle();
        set_tab(8'd0);
        put(TAB, 0); put("q", 0); put(TAB, 0); put("1", 0); put(LF, 0);
        settle();
        set_tab(8'd1);

        // random part with several tab settings
        rnd_phase = 1;
        start_chars = n_chars;
        for (int ph = 0; ph < 4; ph++) begin
            while (n_chars - start_chars < (ph + 1) * 225) rnd_token();
            settle();
            set_tab(ph == 2 ? 8'd4 : 8'($urandom_range(0, 255)));
        end

        $display("Scanned %0d characters into %0d results (%0d token ends)",
                 n_chars, n_results, n_ends);
        $display("Covered all token kinds, error kinds, tab widths 0/1/4/255, column saturation");
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", fails);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
